// ----- design/polynomial_cam_profile_defines.svh -----
// Assertion macros for the cam profile block.
`ifndef POLYNOMIAL_CAM_PROFILE_DEFINES_SVH
`define POLYNOMIAL_CAM_PROFILE_DEFINES_SVH
`ifndef SYNTH
`define PCP_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("%m: lbl failed");
`define PCP_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("%m: lbl failed");
`else
`define PCP_ASSERT_IMP(lbl, clk, rstn, a, c)
`define PCP_ASSERT_NXT(lbl, clk, rstn, a, c)
`endif
`endif

// ----- design/pcp_pkg.sv -----
`default_nettype none
package pcp_pkg;
  localparam int OutFracBits = 16;
  localparam int RndShift    = 38 - OutFracBits;
  localparam logic [15:0] FullTurn = 16'd46080;
  localparam int QDepth = 4;
  localparam int QAw    = 2;

  typedef enum logic [1:0] {
    KIND_DWELL = 2'd0,
    KIND_P4567 = 2'd1,
    KIND_P345  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CFG_H1   = 2'd0,
    CFG_H2   = 2'd1,
    CFG_H3   = 2'd2,
    CFG_RATE = 2'd3
  } cfg_idx_t;

  // classified item passed front -> back
  typedef struct packed {
    logic        oor;
    logic [3:0]  seg;
    kind_t       kind;
    logic [15:0] offs;   // angle - start
    logic [13:0] span;
    logic [1:0]  hfrom;
    logic [1:0]  hto;
    logic [4:0]  mult;
  } item_t;

  typedef struct packed {
    logic [15:0] start;
    logic [13:0] span;
    kind_t       kind;
    logic [1:0]  hfrom;
    logic [1:0]  hto;
    logic [4:0]  mult;
  } seg_t;

  function automatic seg_t seg_of(input logic [3:0] i);
    seg_t s;
    s = '0;
    unique case (i)
      4'd0: s = '{16'd0,     14'd7680,  KIND_P4567, 2'd0, 2'd1, 5'd6};
      4'd1: s = '{16'd7680,  14'd3840,  KIND_DWELL, 2'd1, 2'd1, 5'd12};
      4'd2: s = '{16'd11520, 14'd3840,  KIND_P345,  2'd1, 2'd0, 5'd12};
      4'd3: s = '{16'd15360, 14'd11520, KIND_DWELL, 2'd0, 2'd0, 5'd4};
      4'd4: s = '{16'd26880, 14'd2560,  KIND_P345,  2'd0, 2'd2, 5'd18};
      4'd5: s = '{16'd29440, 14'd2560,  KIND_DWELL, 2'd2, 2'd2, 5'd18};
      4'd6: s = '{16'd32000, 14'd2560,  KIND_P345,  2'd2, 2'd3, 5'd18};
      4'd7: s = '{16'd34560, 14'd3840,  KIND_DWELL, 2'd3, 2'd3, 5'd12};
      4'd8: s = '{16'd38400, 14'd3840,  KIND_P345,  2'd3, 2'd0, 5'd12};
      4'd9: s = '{16'd42240, 14'd3840,  KIND_DWELL, 2'd0, 2'd0, 5'd12};
      default: s = '{16'd42240, 14'd3840, KIND_DWELL, 2'd0, 2'd0, 5'd12};
    endcase
    return s;
  endfunction

  function automatic logic signed [15:0] coef(input kind_t k, input logic [1:0] d,
                                             input logic [2:0] i);
    logic signed [15:0] c;
    c = '0;
    if (k == KIND_P4567) begin
      unique case ({d, i})
        5'b00_100: c = 16'sd35;   5'b00_101: c = -16'sd84;
        5'b00_110: c = 16'sd70;   5'b00_111: c = -16'sd20;
        5'b01_011: c = 16'sd140;  5'b01_100: c = -16'sd420;
        5'b01_101: c = 16'sd420;  5'b01_110: c = -16'sd140;
        5'b10_010: c = 16'sd420;  5'b10_011: c = -16'sd1680;
        5'b10_100: c = 16'sd2100; 5'b10_101: c = -16'sd840;
        5'b11_001: c = 16'sd840;  5'b11_010: c = -16'sd5040;
        5'b11_011: c = 16'sd8400; 5'b11_100: c = -16'sd4200;
        default:   c = '0;
      endcase
    end else begin
      unique case ({d, i})
        5'b00_011: c = 16'sd10;   5'b00_100: c = -16'sd15;
        5'b00_101: c = 16'sd6;
        5'b01_010: c = 16'sd30;   5'b01_011: c = -16'sd60;
        5'b01_100: c = 16'sd30;
        5'b10_001: c = 16'sd60;   5'b10_010: c = -16'sd180;
        5'b10_011: c = 16'sd120;
        5'b11_000: c = 16'sd60;   5'b11_001: c = -16'sd360;
        5'b11_010: c = 16'sd360;
        default:   c = '0;
      endcase
    end
    return c;
  endfunction
endpackage
`default_nettype wire

// ----- design/pcp_front.sv -----
`default_nettype none
// Front: range check and segment lookup, one item per cycle.
module pcp_front import pcp_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  input  wire  [15:0] in_cam_angle,
  output logic        vld_r,
  output item_t       itm_r
);
  logic [3:0] idx;
  seg_t       sg;
  item_t      itm_nxt;

  always_comb begin
    idx = '0;
    for (int i = 1; i < 10; i++)
      if (in_cam_angle >= seg_of(4'(i)).start) idx = 4'(i);
    sg = seg_of(idx);
    itm_nxt = '0;
    if (in_cam_angle > FullTurn) begin
      itm_nxt.oor  = 1'b1;
      itm_nxt.kind = KIND_DWELL;
    end else begin
      itm_nxt.seg   = idx;
      itm_nxt.kind  = sg.kind;
      itm_nxt.offs  = in_cam_angle - sg.start;
      itm_nxt.span  = sg.span;
      itm_nxt.hfrom = sg.hfrom;
      itm_nxt.hto   = sg.hto;
      itm_nxt.mult  = sg.mult;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else        vld_r <= start;
    itm_r <= itm_nxt;
  end
endmodule
`default_nettype wire

// ----- design/pcp_queue.sv -----
`default_nettype none
`include "polynomial_cam_profile_defines.svh"
// Short FIFO between classifier and datapath.
module pcp_queue import pcp_pkg::*; (
  input  wire    clk,
  input  wire    rst_n,
  input  wire    wr_en,
  input  item_t  wr_data,
  input  wire    rd_en,
  output item_t  rd_data,
  output logic   empty,
  output logic   full
);
  item_t         mem_r [QDepth];
  logic [QAw:0]  wp_r, rp_r;

  assign empty   = (wp_r == rp_r);
  assign full    = (wp_r[QAw] != rp_r[QAw]) && (wp_r[QAw-1:0] == rp_r[QAw-1:0]);
  assign rd_data = mem_r[rp_r[QAw-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      if (wr_en && !full) wp_r <= wp_r + 1'b1;
      if (rd_en && !empty) rp_r <= rp_r + 1'b1;
    end
    if (wr_en && !full) mem_r[wp_r[QAw-1:0]] <= wr_data;
  end

  `PCP_ASSERT_IMP(a_no_ovf, clk, rst_n, full, !wr_en || rd_en)
  `PCP_ASSERT_NXT(a_fill, clk, rst_n, wr_en && !rd_en && !full, !empty)
  `PCP_ASSERT_IMP(a_exclusive, clk, rst_n, 1'b1, !(full && empty))
endmodule
`default_nettype wire

// ----- design/pcp_back.sv -----
`default_nettype none
// Back: fully pipelined datapath, one item per cycle.
// Stages: u by reciprocal multiply (2), powers (6), sums (3), height product and
// g scaling (4), round (1).
module pcp_back import pcp_pkg::*; (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_vld,
  input  item_t        in_itm,
  input  wire   [15:0] h1,
  input  wire   [15:0] h2,
  input  wire   [15:0] h3,
  input  wire   [23:0] rate,
  output logic         out_vld,
  output logic  [23:0] displacement,
  output logic  [39:0] velocity,
  output logic  [39:0] acceleration,
  output logic  [39:0] jerk,
  output logic  [3:0]  seg_idx,
  output logic         oor
);
  localparam int DivStg = 2;   // product, then shift
  localparam int NPip   = DivStg + 6 + 3 + 3 + 2;
  localparam logic [63:0] MagCap = 64'h4000_0000_0000_0000;
  // ceil(2^39 / 15) and ceil(2^36 / 5)
  localparam logic [35:0] Rcp15 = 36'd36650387593;
  localparam logic [35:0] Rcp5  = 36'd13743895348;

  typedef struct packed {
    item_t              it;
    logic signed [16:0] dh;
    logic        [15:0] hs;
    logic        [29:0] g;
  } ctl_t;

  function automatic logic [15:0] hsel(input logic [1:0] s, input logic [15:0] a,
                                       input logic [15:0] b, input logic [15:0] c);
    logic [15:0] r;
    unique case (s)
      2'd1: r = a;
      2'd2: r = b;
      2'd3: r = c;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] sstep(input logic [63:0] m, input logic [29:0] g);
    logic [63:0] lo, hi, r;
    lo = {32'd0, m[31:0]} * {34'd0, g};
    hi = {32'd0, m[63:32]} * {34'd0, g};
    if (hi >= (MagCap >> 16)) r = MagCap;
    else begin
      r = (hi << 16) + ((lo + 64'd32768) >> 16);
      if (r > MagCap) r = MagCap;
    end
    return r;
  endfunction

  function automatic logic [39:0] fin(input logic neg, input logic [63:0] m0);
    logic [63:0] m;
    logic [39:0] r;
    m = (m0 + (64'd1 << (RndShift - 1))) >> RndShift;
    if (neg) begin
      if (m > 64'h80_0000_0000) m = 64'h80_0000_0000;
      r = 40'(64'd0 - m);
    end else r = (m > 64'h7F_FFFF_FFFF) ? 40'h7F_FFFF_FFFF : m[39:0];
    return r;
  endfunction

  // control pipeline
  logic [NPip-1:0] v_r;
  ctl_t            c_r [NPip];
  ctl_t            c0;

  always_comb begin
    c0.it = in_itm;
    c0.hs = hsel(in_itm.hfrom, h1, h2, h3);
    c0.dh = $signed({1'b0, hsel(in_itm.hto, h1, h2, h3)}) - $signed({1'b0, c0.hs});
    c0.g  = 30'(rate * in_itm.mult);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= {v_r[NPip-2:0], in_vld};
    c_r[0] <= c0;
    for (int i = 1; i < NPip; i++) c_r[i] <= c_r[i-1];
  end

  // u = (offs << 30) / span; motion spans are 15 * 2^9, 15 * 2^8 and 5 * 2^9,
  // so a reciprocal multiply and a shift give the exact quotient for offs < span.
  // Other spans (the 11520 dwell, out-of-range items) yield 0; u is unused for dwell segments.
  logic [35:0] rcp;
  logic [4:0]  rsh;
  logic [51:0] up_r;
  logic [4:0]  ush_r;
  logic [30:0] u_r;
  always_comb begin
    unique case (in_itm.span)
      14'd7680: begin rcp = Rcp15; rsh = 5'd18; end
      14'd3840: begin rcp = Rcp15; rsh = 5'd17; end
      14'd2560: begin rcp = Rcp5;  rsh = 5'd15; end
      default:  begin rcp = '0;    rsh = 5'd15; end
    endcase
  end

  always_ff @(posedge clk) begin
    up_r  <= 52'(in_itm.offs * rcp);
    ush_r <= rsh;
    u_r   <= 31'(up_r >> ush_r);
  end

  // powers, one multiply per stage
  logic [30:0] pw_r [6][8];
  always_ff @(posedge clk) begin
    for (int s = 0; s < 6; s++) begin
      for (int i = 0; i < 8; i++) begin
        logic [30:0] cur;
        cur = (s == 0) ? ((i == 0) ? 31'h4000_0000 : (i == 1) ? u_r : '0)
                       : pw_r[s-1][i];
        if (i == s + 2) begin
          logic [61:0] pp;
          pp  = (s == 0 ? u_r : pw_r[s-1][i-1]) *
                (s == 0 ? u_r : pw_r[s-1][1]);
          cur = pp[60:30];
        end
        pw_r[s][i] <= cur;
      end
    end
  end

  // polynomial sums: terms, then partial sums, then total
  localparam int P0 = DivStg + 6;
  logic signed [47:0] tm_r [4][8];
  logic signed [47:0] ps_r [4][2];
  logic signed [47:0] p_r  [4];
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 8; i++)
        tm_r[k][i] <= 48'(coef(c_r[P0-1].it.kind, 2'(k), 3'(i)) *
                          $signed({1'b0, pw_r[5][i]}));
      ps_r[k][0] <= tm_r[k][0] + tm_r[k][1] + tm_r[k][2] + tm_r[k][3];
      ps_r[k][1] <= tm_r[k][4] + tm_r[k][5] + tm_r[k][6] + tm_r[k][7];
      p_r[k]     <= ps_r[k][0] + ps_r[k][1];
    end
  end

  // height product, magnitude and sign, then g scaling
  localparam int P1 = P0 + 3;
  logic [63:0] mg_r [4][4];
  logic [3:0]  ng_r [4];
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      logic signed [64:0] pr;
      pr = 65'(c_r[P1-1].dh * p_r[k]);
      ng_r[0][k] <= pr[64];
      mg_r[0][k] <= pr[64] ? 64'(-pr) : pr[63:0];
    end
    for (int s = 1; s < 4; s++) begin
      ng_r[s] <= ng_r[s-1];
      for (int k = 0; k < 4; k++)
        mg_r[s][k] <= (k >= s) ? sstep(mg_r[s-1][k], c_r[P1 + s - 1].g) : mg_r[s-1][k];
    end
  end

  // displacement and final rounding
  localparam int P2 = P1 + 3;
  logic [23:0] d_o_r;
  logic [39:0] v_o_r, a_o_r, j_o_r;
  always_ff @(posedge clk) begin
    ctl_t c;
    logic signed [65:0] dsg;
    logic [65:0] dd;
    c = c_r[P2];
    if (c.it.oor) begin
      d_o_r <= '0; v_o_r <= '0; a_o_r <= '0; j_o_r <= '0;
    end else if (c.it.kind == KIND_DWELL) begin
      dd = (({50'd0, c.hs}) << 30) + (66'd1 << (RndShift - 1));
      dd = dd >> RndShift;
      d_o_r <= (dd > 66'hFF_FFFF) ? 24'hFF_FFFF : dd[23:0];
      v_o_r <= '0; a_o_r <= '0; j_o_r <= '0;
    end else begin
      dsg = ($signed({50'd0, c.hs}) <<< 30) +
            (ng_r[3][0] ? -$signed({2'b0, mg_r[3][0]}) : $signed({2'b0, mg_r[3][0]}));
      if (dsg < 0) d_o_r <= '0;
      else begin
        dd = (66'(dsg) + (66'd1 << (RndShift - 1))) >> RndShift;
        d_o_r <= (dd > 66'hFF_FFFF) ? 24'hFF_FFFF : dd[23:0];
      end
      v_o_r <= fin(ng_r[3][1], mg_r[3][1]);
      a_o_r <= fin(ng_r[3][2], mg_r[3][2]);
      j_o_r <= fin(ng_r[3][3], mg_r[3][3]);
    end
  end

  assign out_vld      = v_r[NPip-1];
  assign displacement = d_o_r;
  assign velocity     = v_o_r;
  assign acceleration = a_o_r;
  assign jerk         = j_o_r;
  assign seg_idx      = c_r[NPip-1].it.oor ? 4'd0 : c_r[NPip-1].it.seg;
  assign oor          = c_r[NPip-1].it.oor;
endmodule
`default_nettype wire

// ----- design/polynomial_cam_profile.sv -----
// The front register loads at the accepting edge; the item then passes one queue stage
// and the 16 datapath stages before out_valid rises.
// Throughput: one item per cycle; busy is never raised in steady state since the
// datapath is a fixed pipeline and drains the queue each cycle.
// Reset: rst_n synchronous active low; clears valid pipes and queue pointers and
// loads the height and rate registers with their defaults.
`default_nettype none
`include "polynomial_cam_profile_defines.svh"
module polynomial_cam_profile import pcp_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire  [15:0] in_cam_angle,
  output logic        out_valid,
  output logic [23:0] out_displacement,
  output logic signed [39:0] out_velocity,
  output logic signed [39:0] out_acceleration,
  output logic signed [39:0] out_jerk,
  output logic [3:0]  out_segment_index,
  output logic        out_out_of_range,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [23:0] cfg_data
);
  // The receiver cannot stall: each result shows for one cycle with out_valid.
  // configuration registers
  logic [15:0] h1_r, h2_r, h3_r;
  logic [23:0] rate_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h1_r <= 16'd10240; h2_r <= 16'd12800; h3_r <= 16'd7680; rate_r <= 24'd13107;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_H1:   h1_r   <= cfg_data[15:0];
        CFG_H2:   h2_r   <= cfg_data[15:0];
        CFG_H3:   h3_r   <= cfg_data[15:0];
        CFG_RATE: rate_r <= cfg_data;
        default:  h1_r   <= h1_r;
      endcase
    end
  end

  logic  f_vld, q_empty, q_full;
  item_t f_itm, q_itm;
  logic  acc;

  // queue always drains one per cycle; busy only guards a full queue
  assign busy = q_full;
  assign acc  = start && !busy;

  pcp_front u_front (
    .clk(clk), .rst_n(rst_n), .start(acc), .in_cam_angle(in_cam_angle),
    .vld_r(f_vld), .itm_r(f_itm)
  );

  pcp_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_en(f_vld), .wr_data(f_itm),
    .rd_en(!q_empty), .rd_data(q_itm), .empty(q_empty), .full(q_full)
  );

  pcp_back u_back (
    .clk(clk), .rst_n(rst_n), .in_vld(!q_empty), .in_itm(q_itm),
    .h1(h1_r), .h2(h2_r), .h3(h3_r), .rate(rate_r),
    .out_vld(out_valid), .displacement(out_displacement),
    .velocity(out_velocity), .acceleration(out_acceleration), .jerk(out_jerk),
    .seg_idx(out_segment_index), .oor(out_out_of_range)
  );

  `PCP_ASSERT_NXT(a_front_follows, clk, rst_n, acc, f_vld)
  `PCP_ASSERT_IMP(a_oor_zero, clk, rst_n, out_valid && out_out_of_range,
                  out_displacement == 24'd0 && out_segment_index == 4'd0)
  `PCP_ASSERT_IMP(a_seg_range, clk, rst_n, out_valid, out_segment_index <= 4'd9)
endmodule
`default_nettype wire

// ----- tb/polynomial_cam_profile_checker.sv -----
`default_nettype none
module polynomial_cam_profile_checker import pcp_pkg::*; (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  input  wire                busy,
  input  wire         [15:0] in_cam_angle,
  input  wire                out_valid,
  input  wire         [23:0] out_displacement,
  input  wire  signed [39:0] out_velocity,
  input  wire  signed [39:0] out_acceleration,
  input  wire  signed [39:0] out_jerk,
  input  wire         [3:0]  out_segment_index,
  input  wire                out_out_of_range,
  input  wire                cfg_valid,
  input  wire                cfg_ready,
  input  wire         [1:0]  cfg_index,
  input  wire         [23:0] cfg_data,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [23:0] disp;
    logic [39:0] vel;
    logic [39:0] acc;
    logic [39:0] jrk;
    logic [3:0]  seg;
    logic        oor;
  } cam_out_t;

  logic [15:0] h1, h2, h3;
  logic [23:0] rate;
  cam_out_t    cam_q[$];

  localparam logic [63:0] MagCap = 64'd1 << 62;
  localparam logic [63:0] DMax   = 64'h7F_FFFF_FFFF;

  function automatic logic [15:0] height_sel(input logic [1:0] sel);
    case (sel)
      2'd1: return h1;
      2'd2: return h2;
      2'd3: return h3;
      default: return 16'd0;
    endcase
  endfunction

  function automatic logic [63:0] gain_step(input logic [63:0] m, input logic [63:0] g);
    logic [63:0] lo, hi, r;
    lo = {32'd0, m[31:0]} * g;
    hi = {32'd0, m[63:32]} * g;
    if (hi >= (MagCap >> 16)) return MagCap;
    r = (hi << 16) + ((lo + 64'd32768) >> 16);
    return (r > MagCap) ? MagCap : r;
  endfunction

  function automatic logic [39:0] deriv_out(input longint prod, input logic [63:0] g,
                                            input int order);
    logic        neg;
    logic [63:0] m;
    neg = prod < 0;
    m = neg ? 64'd0 - 64'(prod) : 64'(prod);
    for (int i = 0; i < order; i++) m = gain_step(m, g);
    m = (m + (64'd1 << (RndShift - 1))) >> RndShift;
    if (neg) begin
      if (m > DMax + 1) m = DMax + 1;
      return 40'(64'd0 - m);
    end
    return (m > DMax) ? DMax[39:0] : m[39:0];
  endfunction

  function automatic cam_out_t cam_predict(input logic [15:0] a);
    cam_out_t    r;
    seg_t        sg;
    logic [3:0]  idx;
    longint      hs, dh, disp;
    longint      pw[8];
    longint      p[4];
    logic [63:0] u, g, d;
    r = '{default: '0};
    if (a > FullTurn) begin
      r.oor = 1'b1;
      return r;
    end
    idx = 0;
    for (int i = 1; i < 10; i++) if (a >= seg_of(4'(i)).start) idx = 4'(i);
    sg = seg_of(idx);
    r.seg = idx;
    hs = longint'(height_sel(sg.hfrom));
    if (sg.kind == KIND_DWELL) begin
      d = ((64'(hs) << 30) + (64'd1 << (RndShift - 1))) >> RndShift;
      r.disp = (d > 64'hFF_FFFF) ? 24'hFF_FFFF : d[23:0];
      return r;
    end
    dh = longint'(height_sel(sg.hto)) - hs;
    u = (64'(a - sg.start) << 30) / 64'(sg.span);
    pw[0] = longint'(1) << 30;
    pw[1] = longint'(u);
    for (int i = 2; i < 8; i++) pw[i] = longint'((64'(pw[i-1]) * u) >> 30);
    for (int k = 0; k < 4; k++) begin
      p[k] = 0;
      for (int i = 0; i < 8; i++)
        p[k] += longint'(coef(sg.kind, 2'(k), 3'(i))) * pw[i];
    end
    disp = hs * (longint'(1) << 30) + dh * p[0];
    if (disp >= 0) begin
      d = (64'(disp) + (64'd1 << (RndShift - 1))) >> RndShift;
      r.disp = (d > 64'hFF_FFFF) ? 24'hFF_FFFF : d[23:0];
    end
    g = 64'(rate) * 64'(sg.mult);
    r.vel = deriv_out(dh * p[1], g, 1);
    r.acc = deriv_out(dh * p[2], g, 2);
    r.jrk = deriv_out(dh * p[3], g, 3);
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [39:0] exp_v,
                               input logic [39:0] act_v);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t mismatch %s: expected %h actual %h", $realtime, what, exp_v, act_v);
  endtask

  assign pending = cam_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    cam_out_t e;
    if (!rst_n) begin
      h1 <= 16'd10240;
      h2 <= 16'd12800;
      h3 <= 16'd7680;
      rate <= 24'd13107;
      cam_q.delete();
    end else begin
      if (out_valid) begin
        if (cam_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("%0t unexpected item on output", $realtime);
        end else begin
          e = cam_q.pop_front();
          if (out_displacement !== e.disp)
            flag_mismatch("displacement", 40'(e.disp), 40'(out_displacement));
          if (out_velocity !== e.vel) flag_mismatch("velocity", e.vel, out_velocity);
          if (out_acceleration !== e.acc)
            flag_mismatch("acceleration", e.acc, out_acceleration);
          if (out_jerk !== e.jrk) flag_mismatch("jerk", e.jrk, out_jerk);
          if (out_segment_index !== e.seg)
            flag_mismatch("segment_index", 40'(e.seg), 40'(out_segment_index));
          if (out_out_of_range !== e.oor)
            flag_mismatch("out_of_range", 40'(e.oor), 40'(out_out_of_range));
        end
      end
      if (start && !busy) cam_q.push_back(cam_predict(in_cam_angle));
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_H1:   h1 <= cfg_data[15:0];
          CFG_H2:   h2 <= cfg_data[15:0];
          CFG_H3:   h3 <= cfg_data[15:0];
          CFG_RATE: rate <= cfg_data;
          default: ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

// ----- tb/polynomial_cam_profile_tb.sv -----
`default_nettype none
module polynomial_cam_profile_tb import pcp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // pipeline depth from the block header, plus margin for the end drain
  localparam int LatencyCycles = 17;
  localparam int DrainCycles   = LatencyCycles + 10;
  localparam int WatchdogLimit = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [15:0] in_cam_angle = '0;
  logic cfg_valid = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  wire busy, out_valid, cfg_ready, out_out_of_range;
  wire [23:0] out_displacement;
  wire signed [39:0] out_velocity, out_acceleration, out_jerk;
  wire [3:0] out_segment_index;
  int fail_count, pending;
  int idle_cycles = 0;

  always #6 clk = ~clk;

  polynomial_cam_profile DUT (.*);
  polynomial_cam_profile_checker u_checker (.*);

  // watchdog: cycles without any accepted item, result or register write
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("polynomial_cam_profile verification failed");
      $finish;
    end
  end

  // no gap or a short one most of the time, sometimes a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_angle(input logic [15:0] a);
    int g;
    start <= 1'b1;
    in_cam_angle <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    g = gap_len();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // only called once start is low and the pipe has drained
  task automatic write_reg(input cfg_idx_t idx, input logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    repeat (gap_len()) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // biased angle: segment edges, interior points, out-of-range values
  function automatic logic [15:0] rand_angle();
    int r;
    logic [15:0] edges[11] = '{16'd0, 16'd7680, 16'd11520, 16'd15360, 16'd26880,
                               16'd29440, 16'd32000, 16'd34560, 16'd38400,
                               16'd42240, 16'd46080};
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(0, 46080));
    if (r < 85) return 16'(int'(edges[$urandom_range(0, 10)]) + $urandom_range(0, 2) - 1);
    return 16'($urandom_range(46081, 65535));
  endfunction

  initial begin
    logic [15:0] directed[$];
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: each segment start, segment interiors, full turn and beyond
    directed = '{16'd0, 16'd1, 16'd3840, 16'd7679, 16'd7680, 16'd9000, 16'd11520,
                 16'd13440, 16'd15359, 16'd15360, 16'd26880, 16'd28160, 16'd29440,
                 16'd32000, 16'd33280, 16'd34560, 16'd38400, 16'd40320, 16'd42239,
                 16'd42240, 16'd46080, 16'd46081, 16'hFFFF, 16'h5555, 16'hAAAA};
    foreach (directed[i]) send_angle(directed[i]);
    drain();

    // several register settings: extremes, zero rate effect via min rate, random
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_H1, 24'hFFFF); write_reg(CFG_H2, 24'hFFFF);
          write_reg(CFG_H3, 24'h0000); write_reg(CFG_RATE, 24'hFF_FFFF);
        end
        1: begin
          write_reg(CFG_H1, 24'h0000); write_reg(CFG_H2, 24'h0000);
          write_reg(CFG_H3, 24'hFFFF); write_reg(CFG_RATE, 24'd1);
        end
        2: begin
          write_reg(CFG_H1, 24'h0001); write_reg(CFG_H2, 24'hFFFE);
          write_reg(CFG_H3, 24'h8000); write_reg(CFG_RATE, 24'h80_0000);
        end
        default: begin
          write_reg(CFG_H1, 24'($urandom_range(0, 65535)));
          write_reg(CFG_H2, 24'($urandom_range(0, 65535)));
          write_reg(CFG_H3, 24'($urandom_range(0, 65535)));
          write_reg(CFG_RATE, (phase == 7) ? 24'd13107 : 24'($urandom_range(1, 24'hFF_FFFF)));
        end
      endcase
      for (int n = 0; n < 105; n++) begin
        send_angle(rand_angle());
        // hold off mid-phase until every expected result has come
        if (n == 50) drain();
      end
      drain();
    end

    if (fail_count == 0)
      $display("polynomial_cam_profile verification clean");
    else
      $display("polynomial_cam_profile verification failed");
    $finish;
  end
endmodule
`default_nettype wire
